// ===== hw/rtl/tdc_pkg.sv =====
// shared types and constants of the tile duplicate counter
package tdc_pkg;

	// field widths of the request and result items
	localparam int unsigned CFG_W      = 4;
	localparam int unsigned COORD_W    = 7;
	localparam int unsigned TILE_IDX_W = 3;
	localparam int unsigned PIX_W      = 24;
	localparam int unsigned COUNT_W    = 7;

	// match count saturates here
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// configuration port
	localparam int unsigned APB_AW      = 3;
	localparam int unsigned APB_DW      = 32;
	localparam int unsigned REG_SEL_BIT = 2;
	localparam logic        REG_TILES_ACROSS = 1'b0;
	localparam logic        REG_TILES_DOWN   = 1'b1;
	localparam logic [CFG_W-1:0] CFG_RESET   = 4'd8;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} tdc_op_t;

	typedef struct packed {
		tdc_op_t                 operation;
		logic [COORD_W-1:0]      pixel_column;
		logic [COORD_W-1:0]      pixel_row;
		logic [PIX_W-1:0]        pixel_value;
		logic [TILE_IDX_W-1:0]   tile_column;
		logic [TILE_IDX_W-1:0]   tile_row;
	} tdc_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]      origin_x;
		logic [COORD_W-1:0]      origin_y;
		logic [COUNT_W-1:0]      match_count;
		logic                    unique_res;
	} tdc_result_t;

	typedef struct packed {
		logic [CFG_W-1:0]        tiles_across;
		logic [CFG_W-1:0]        tiles_down;
	} tdc_cfg_t;

endpackage

// ===== hw/rtl/tdc_if.sv =====
// request and result channel interfaces of the tile duplicate counter
interface tdc_item_if import tdc_pkg::*; ();
	logic      valid;
	logic      ready;
	tdc_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tdc_result_if import tdc_pkg::*; ();
	logic        valid;
	logic        ready;
	tdc_result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tdc_apb_regs.sv =====
// apb configuration registers: tile counts across and down
module tdc_apb_regs import tdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output tdc_cfg_t          cfg
);

	logic     wr_en;
	logic     reg_sel;
	tdc_cfg_t cfg_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[REG_SEL_BIT];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tiles_across <= CFG_RESET;
			cfg_q.tiles_down   <= CFG_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_TILES_ACROSS: cfg_q.tiles_across <= pwdata[CFG_W-1:0];
				REG_TILES_DOWN:   cfg_q.tiles_down   <= pwdata[CFG_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_sel)
			REG_TILES_ACROSS: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.tiles_across};
			REG_TILES_DOWN:   prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.tiles_down};
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/tdc_pixel_store.sv =====
// single-port image memory with registered read
module tdc_pixel_store import tdc_pkg::*; #(
	parameter int unsigned DEPTH = 16384,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PIX_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;

	// one access per cycle, write wins
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end else if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== hw/rtl/tdc_scan_ctrl.sv =====
// request decode, tile scan sequencer, tile copy buffer, compare and count
module tdc_scan_ctrl import tdc_pkg::*; #(
	parameter int unsigned MAX_TILES_ACROSS = 8,
	parameter int unsigned MAX_TILES_DOWN   = 8,
	parameter int unsigned TILE_SIZE        = 16,
	localparam int unsigned STORE_W  = MAX_TILES_ACROSS * TILE_SIZE,
	localparam int unsigned STORE_H  = MAX_TILES_DOWN * TILE_SIZE,
	localparam int unsigned AW       = $clog2(STORE_W * STORE_H)
) (
	input  logic               clk,
	input  logic               arst_n,
	tdc_item_if.sink           item,
	tdc_result_if.source       result,
	input  tdc_cfg_t           cfg,
	output logic               st_wr_en,
	output logic [AW-1:0]      st_wr_addr,
	output logic [PIX_W-1:0]   st_wr_data,
	output logic               st_rd_en,
	output logic [AW-1:0]      st_rd_addr,
	input  logic [PIX_W-1:0]   st_rd_data
);

	localparam int unsigned TILE_PIX = TILE_SIZE * TILE_SIZE;
	localparam int unsigned PW       = $clog2(TILE_PIX);
	localparam int unsigned TW       = $clog2(TILE_SIZE);
	localparam int unsigned XW       = $clog2(STORE_W);
	localparam int unsigned YW       = $clog2(STORE_H);
	localparam int unsigned ACW      = $clog2(MAX_TILES_ACROSS + 1);
	localparam int unsigned DCW      = $clog2(MAX_TILES_DOWN + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_COPY  = 5'b00010,
		ST_CMP   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} tdc_state_t;

	tdc_state_t state_q;

	logic [ACW-1:0] across_eff;
	logic [DCW-1:0] down_eff;

	logic           accept;
	logic           load_ok;
	logic           query_ok;

	// pixel walker inside the tile being scanned
	logic [TW-1:0]  ix_q;
	logic [TW-1:0]  iy_q;
	logic [PW-1:0]  pidx_q;
	logic [XW-1:0]  bx_q;
	logic [YW-1:0]  by_q;
	logic [ACW-1:0] tcx_q;
	logic [DCW-1:0] tcy_q;
	logic           last_pix;
	logic           last_col;
	logic           last_tile;

	// queried tile
	logic [TILE_IDX_W-1:0] qtc_q;
	logic [TILE_IDX_W-1:0] qtr_q;

	// read data stage
	logic           v_s1;
	logic           cmp_s1;
	logic           first_s1;
	logic           last_s1;
	logic [PW-1:0]  pidx_s1;

	logic [PIX_W-1:0] copy_mem [TILE_PIX];
	logic [PIX_W-1:0] copy_rd_q;
	logic             tile_eq;
	logic             acc_q;
	logic [COUNT_W-1:0] count_q;

	logic        load_res;
	logic        res_valid_q;
	tdc_result_t res_q;

	// out-of-range tile counts fold into 1..max
	always_comb begin
		if (cfg.tiles_across == '0) begin
			across_eff = ACW'(1);
		end else if (int'(cfg.tiles_across) > int'(MAX_TILES_ACROSS)) begin
			across_eff = ACW'(MAX_TILES_ACROSS);
		end else begin
			across_eff = ACW'(cfg.tiles_across);
		end
		if (cfg.tiles_down == '0) begin
			down_eff = DCW'(1);
		end else if (int'(cfg.tiles_down) > int'(MAX_TILES_DOWN)) begin
			down_eff = DCW'(MAX_TILES_DOWN);
		end else begin
			down_eff = DCW'(cfg.tiles_down);
		end
	end

	// request decode
	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign load_ok    = (item.data.operation == OP_LOAD)
		&& (int'(item.data.pixel_column) < int'(STORE_W))
		&& (int'(item.data.pixel_row) < int'(STORE_H));
	assign query_ok   = (item.data.operation == OP_QUERY)
		&& (int'(item.data.tile_column) < int'(across_eff))
		&& (int'(item.data.tile_row) < int'(down_eff));

	// pixel loads go straight into the store
	assign st_wr_en   = accept && load_ok;
	assign st_wr_addr = AW'(int'(item.data.pixel_row) * int'(STORE_W)
		+ int'(item.data.pixel_column));
	assign st_wr_data = item.data.pixel_value;

	// store read for the current walker position
	assign st_rd_en   = (state_q == ST_COPY) || (state_q == ST_CMP);
	assign st_rd_addr = AW'((int'(by_q) + int'(iy_q)) * int'(STORE_W)
		+ int'(bx_q) + int'(ix_q));

	assign last_pix  = (pidx_q == PW'(TILE_PIX - 1));
	assign last_col  = (tcx_q == across_eff - ACW'(1));
	assign last_tile = last_col && (tcy_q == down_eff - DCW'(1));

	// sequencer and walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ix_q    <= '0;
			iy_q    <= '0;
			pidx_q  <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			tcx_q   <= '0;
			tcy_q   <= '0;
			qtc_q   <= '0;
			qtr_q   <= '0;
		end else begin
			if (st_rd_en) begin
				if (last_pix) begin
					ix_q   <= '0;
					iy_q   <= '0;
					pidx_q <= '0;
				end else begin
					pidx_q <= pidx_q + PW'(1);
					if (ix_q == TW'(TILE_SIZE - 1)) begin
						ix_q <= '0;
						iy_q <= iy_q + TW'(1);
					end else begin
						ix_q <= ix_q + TW'(1);
					end
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && query_ok) begin
						state_q <= ST_COPY;
						ix_q    <= '0;
						iy_q    <= '0;
						pidx_q  <= '0;
						qtc_q   <= item.data.tile_column;
						qtr_q   <= item.data.tile_row;
						bx_q    <= XW'(int'(item.data.tile_column) * int'(TILE_SIZE));
						by_q    <= YW'(int'(item.data.tile_row) * int'(TILE_SIZE));
					end
				end
				ST_COPY: begin
					if (last_pix) begin
						state_q <= ST_CMP;
						bx_q    <= '0;
						by_q    <= '0;
						tcx_q   <= '0;
						tcy_q   <= '0;
					end
				end
				ST_CMP: begin
					if (last_pix) begin
						if (last_tile) begin
							state_q <= ST_DRAIN;
						end else if (last_col) begin
							tcx_q <= '0;
							bx_q  <= '0;
							tcy_q <= tcy_q + DCW'(1);
							by_q  <= by_q + YW'(TILE_SIZE);
						end else begin
							tcx_q <= tcx_q + ACW'(1);
							bx_q  <= bx_q + XW'(TILE_SIZE);
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read data stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cmp_s1 <= 1'b0;
		end else begin
			v_s1   <= st_rd_en;
			cmp_s1 <= (state_q == ST_CMP);
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (pidx_q == '0);
		last_s1  <= last_pix;
		pidx_s1  <= pidx_q;
	end

	// tile copy buffer: filled in the copy pass, read in the compare pass;
	// the last copy write and the first compare read never hit the same entry
	always_ff @(posedge clk) begin
		if (v_s1 && !cmp_s1) begin
			copy_mem[pidx_s1] <= st_rd_data;
		end
		if (state_q == ST_CMP) begin
			copy_rd_q <= copy_mem[pidx_q];
		end
	end

	// running match of the tile under compare
	assign tile_eq = (st_rd_data == copy_rd_q) && (first_s1 || acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 1'b0;
			count_q <= '0;
		end else if (accept && query_ok) begin
			count_q <= '0;
		end else if (v_s1 && cmp_s1) begin
			acc_q <= tile_eq;
			if (last_s1 && tile_eq && (count_q != COUNT_MAX)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	// result register
	assign load_res = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.origin_x    <= COORD_W'(int'(qtc_q) * int'(TILE_SIZE));
			res_q.origin_y    <= COORD_W'(int'(qtr_q) * int'(TILE_SIZE));
			res_q.match_count <= count_q;
			res_q.unique_res  <= (count_q == COUNT_W'(1));
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// ===== hw/rtl/tile_duplicate_counter_core.sv =====
// top level of the tile duplicate counter
//
// The block holds a 24-bit RGB image of whole square tiles and counts, for
// a queried tile, how many tiles of the image are identical to it.
// Requests arrive on the item channel (valid/ready). A load request writes
// one pixel; it is taken even while a result waits. A query request names
// a tile; the block copies that tile into a local buffer, then compares it
// against every tile of the configured image. The single store read port
// moves one pixel per cycle, and no new request is taken until the query
// has finished. A query naming a tile outside the configured image gives
// no result. Results leave through one output register on the result
// channel; while the receiver stalls with a result in that register,
// requests are still taken until the next query finishes, which then holds
// with ready low until the register is free. The tile counts are set
// through the APB port, registers at byte addresses 0 and 4; the user must
// set them only while the block is idle, the block does not enforce this.
// Reset returns the tile counts to 8 and drops any pending result; the
// image memory is not cleared and must be loaded before it is queried.
module tile_duplicate_counter_core import tdc_pkg::*; #(
	parameter int unsigned MAX_TILES_ACROSS = 8,
	parameter int unsigned MAX_TILES_DOWN   = 8,
	parameter int unsigned TILE_SIZE        = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	tdc_item_if.sink          item,
	tdc_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int unsigned DEPTH = MAX_TILES_ACROSS * TILE_SIZE
		* MAX_TILES_DOWN * TILE_SIZE;
	localparam int unsigned AW    = $clog2(DEPTH);

	tdc_cfg_t         cfg;
	logic             st_wr_en;
	logic [AW-1:0]    st_wr_addr;
	logic [PIX_W-1:0] st_wr_data;
	logic             st_rd_en;
	logic [AW-1:0]    st_rd_addr;
	logic [PIX_W-1:0] st_rd_data;

	// configuration registers
	tdc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer and compare datapath
	tdc_scan_ctrl #(
		.MAX_TILES_ACROSS (MAX_TILES_ACROSS),
		.MAX_TILES_DOWN   (MAX_TILES_DOWN),
		.TILE_SIZE        (TILE_SIZE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg        (cfg),
		.st_wr_en   (st_wr_en),
		.st_wr_addr (st_wr_addr),
		.st_wr_data (st_wr_data),
		.st_rd_en   (st_rd_en),
		.st_rd_addr (st_rd_addr),
		.st_rd_data (st_rd_data)
	);

	// image memory
	tdc_pixel_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	// loads and scan reads never share the store port
	a_store_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_wr_en && st_rd_en))
		else $error("store written and read in the same cycle");

	// unique flag follows the count
	a_unique: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.unique_res ==
			(result.data.match_count == COUNT_W'(1))))
		else $error("unique flag does not match count");

	// a new result only comes out of a busy query
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!item.ready))
		else $error("result raised while idle");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the tile duplicate counter core
module tb import tdc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TILE       = 16;
	localparam int unsigned MAX_ACROSS = 8;
	localparam int unsigned MAX_DOWN   = 8;
	localparam int unsigned STORE_W    = MAX_ACROSS * TILE;
	localparam int unsigned STORE_H    = MAX_DOWN * TILE;
	localparam int unsigned TILE_PIX   = TILE * TILE;

	// the watchdog limit outlasts an 8x8 query and the settle pause after it
	localparam int unsigned WATCHDOG_LIMIT = 100_000;
	localparam int unsigned HOLD_CYCLES    = 3000;
	localparam int unsigned ROUNDS         = 12;

	// random phases: image size and idling of each side
	localparam int unsigned PHASE_ACROSS [4] = '{3, 2, 4, 8};
	localparam int unsigned PHASE_DOWN   [4] = '{1, 3, 2, 2};
	localparam int unsigned SEND_IDLE    [4] = '{0, 63, 0, 10};
	localparam int unsigned STALL        [4] = '{0, 0, 63, 10};

	// where the expected count of a directed row comes from
	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_TYPED,
		EXP_NONE
	} check_src_t;

	typedef struct packed {
		logic                  new_cfg;
		logic [CFG_W-1:0]      across;
		logic [CFG_W-1:0]      down;
		tdc_op_t               operation;
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		logic [PIX_W-1:0]      value;
		logic [TILE_IDX_W-1:0] tc;
		logic [TILE_IDX_W-1:0] tr;
		check_src_t            src;
		tdc_result_t           want;
	} dir_row_t;

	// directed requests; the image starts as 64 copies of one tile
	localparam dir_row_t DIRECTED [20] = '{
		'{1, 15, 15, OP_QUERY, 0, 0, 0, 7, 7, EXP_TYPED, '{112, 112, 64, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 0, 0, EXP_TYPED, '{0, 0, 64, 0}},
		'{1, 0, 0, OP_QUERY, 0, 0, 0, 0, 0, EXP_TYPED, '{0, 0, 1, 1}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 1, 0, EXP_NONE, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 0, 1, EXP_NONE, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 7, 7, EXP_NONE, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_LOAD, 0, 0, 24'h000000, 0, 0, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_LOAD, 127, 127, 24'hffffff, 7, 7, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_LOAD, 127, 0, 24'hffffff, 0, 0, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_LOAD, 0, 127, 24'h000000, 0, 0, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 0, 0, EXP_TYPED, '{0, 0, 1, 1}},
		'{1, 8, 1, OP_QUERY, 0, 0, 0, 7, 0, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 3, 0, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 0, 1, EXP_NONE, '{0, 0, 0, 0}},
		'{1, 1, 8, OP_QUERY, 0, 0, 0, 0, 7, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 0, 4, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 1, 0, EXP_NONE, '{0, 0, 0, 0}},
		'{1, 8, 8, OP_QUERY, 0, 0, 0, 0, 0, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 7, 7, EXP_MODEL, '{0, 0, 0, 0}},
		'{0, 0, 0, OP_QUERY, 0, 0, 0, 4, 4, EXP_MODEL, '{0, 0, 0, 0}}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	tdc_item_if   req_if ();
	tdc_result_if res_if ();

	tile_duplicate_counter_core #(
		.MAX_TILES_ACROSS(MAX_ACROSS),
		.MAX_TILES_DOWN  (MAX_DOWN),
		.TILE_SIZE       (TILE)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_if),
		.result (res_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// own copy of the image and tile counts
	logic [PIX_W-1:0] img_mem [STORE_W*STORE_H];
	logic [PIX_W-1:0] base_tile [TILE_PIX];
	logic [CFG_W-1:0] cfg_across = CFG_RESET;
	logic [CFG_W-1:0] cfg_down   = CFG_RESET;

	tdc_result_t pending_counts [$];
	tdc_result_t oldest;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned errors        = 0;
	int unsigned n_requests    = 0;
	int unsigned n_queries     = 0;
	int unsigned n_results     = 0;
	int unsigned n_cfg_writes  = 0;
	int unsigned quiet_cycles  = 0;
	logic        holding;
	event        hold_off;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// tile count as the block uses it: zero acts as one, too large as the maximum
	function automatic int unsigned eff_count(input logic [CFG_W-1:0] v,
			input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] pix_at(input int unsigned x, input int unsigned y);
		return img_mem[y * STORE_W + x];
	endfunction

	// apply one request to the image copy; returns 1 with the count when it gives one
	function automatic bit count_duplicates(input tdc_item_t rq, output tdc_result_t res);
		logic [PIX_W-1:0] probe [TILE_PIX];
		int unsigned      across, down, x0, y0, n, i, tx, ty;
		bit               same;
		res = '0;
		if (rq.operation == OP_LOAD) begin
			if (rq.pixel_column < STORE_W && rq.pixel_row < STORE_H)
				img_mem[rq.pixel_row * STORE_W + rq.pixel_column] = rq.pixel_value;
			return 1'b0;
		end
		across = eff_count(cfg_across, MAX_ACROSS);
		down   = eff_count(cfg_down, MAX_DOWN);
		if (rq.tile_column >= across || rq.tile_row >= down)
			return 1'b0;
		x0 = rq.tile_column * TILE;
		y0 = rq.tile_row * TILE;
		for (i = 0; i < TILE_PIX; i++)
			probe[i] = pix_at(x0 + i % TILE, y0 + i / TILE);
		// compare against every tile of the image, itself included
		n = 0;
		for (ty = 0; ty < down; ty++) begin
			for (tx = 0; tx < across; tx++) begin
				same = 1'b1;
				for (i = 0; i < TILE_PIX; i++)
					if (probe[i] != pix_at(tx * TILE + i % TILE, ty * TILE + i / TILE))
						same = 1'b0;
				if (same && n < COUNT_MAX)
					n++;
			end
		end
		res.origin_x    = COORD_W'(x0);
		res.origin_y    = COORD_W'(y0);
		res.match_count = COUNT_W'(n);
		res.unique_res  = (n == 1);
		return 1'b1;
	endfunction

	function automatic tdc_item_t load_req(input int unsigned x, input int unsigned y,
			input logic [PIX_W-1:0] v);
		tdc_item_t rq;
		rq.operation    = OP_LOAD;
		rq.pixel_column = COORD_W'(x);
		rq.pixel_row    = COORD_W'(y);
		rq.pixel_value  = v;
		rq.tile_column  = TILE_IDX_W'($urandom);
		rq.tile_row     = TILE_IDX_W'($urandom);
		return rq;
	endfunction

	function automatic tdc_item_t query_req(input int unsigned tc, input int unsigned tr);
		tdc_item_t rq;
		rq.operation    = OP_QUERY;
		rq.pixel_column = COORD_W'($urandom);
		rq.pixel_row    = COORD_W'($urandom);
		rq.pixel_value  = PIX_W'($urandom);
		rq.tile_column  = TILE_IDX_W'(tc);
		rq.tile_row     = TILE_IDX_W'(tr);
		return rq;
	endfunction

	// offer one request, then record what it should produce
	task automatic offer(input tdc_item_t rq, input check_src_t src = EXP_MODEL,
			input tdc_result_t typed = '0);
		tdc_result_t predicted;
		bit          produces;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= rq;
		do @(posedge clk); while (!req_if.ready);
		produces = count_duplicates(rq, predicted);
		case (src)
			EXP_MODEL: begin
				if (produces)
					pending_counts.push_back(predicted);
			end
			EXP_TYPED: begin
				pending_counts.push_back(typed);
			end
			default: ;
		endcase
		n_requests++;
		if (rq.operation == OP_QUERY)
			n_queries++;
	endtask

	// stop sending, let every count arrive, then let a silent query run out
	task automatic wait_quiet();
		req_if.valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (TILE_PIX * (1 + eff_count(cfg_across, MAX_ACROSS) *
				eff_count(cfg_down, MAX_DOWN)) + 16)
			@(posedge clk);
	endtask

	// apb write of one tile count register, then read it back
	task automatic write_tile_count(input logic reg_idx, input logic [CFG_W-1:0] val);
		logic [APB_DW-1:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(reg_idx) << REG_SEL_BIT;
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_idx == REG_TILES_ACROSS)
			cfg_across = val;
		else
			cfg_down = val;
		n_cfg_writes++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (readback[CFG_W-1:0] !== val) begin
			$error("%s readback: expected %0d, got %0d",
				(reg_idx == REG_TILES_ACROSS) ? "tiles_across" : "tiles_down",
				val, readback[CFG_W-1:0]);
			errors++;
		end
	endtask

	task automatic set_tiles(input logic [CFG_W-1:0] across, input logic [CFG_W-1:0] down);
		wait_quiet();
		write_tile_count(REG_TILES_ACROSS, across);
		write_tile_count(REG_TILES_DOWN, down);
	endtask

	// long receiver hold-off, counted here
	initial begin
		holding = 1'b0;
		forever begin
			@(hold_off);
			@(posedge clk);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	// result receiver with random stalls
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_if.ready <= !holding && ($urandom_range(99) >= stall_pct);
		end
	end

	// compare each count with the oldest one waiting
	always @(posedge clk) begin
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			n_results++;
			if (pending_counts.size() == 0) begin
				$error("count with no query waiting: origin %0d,%0d count %0d",
					res_if.data.origin_x, res_if.data.origin_y, res_if.data.match_count);
				errors++;
			end else begin
				oldest = pending_counts.pop_front();
				if (res_if.data.origin_x !== oldest.origin_x) begin
					$error("origin_x: expected %0d, got %0d",
						oldest.origin_x, res_if.data.origin_x);
					errors++;
				end
				if (res_if.data.origin_y !== oldest.origin_y) begin
					$error("origin_y: expected %0d, got %0d",
						oldest.origin_y, res_if.data.origin_y);
					errors++;
				end
				if (res_if.data.match_count !== oldest.match_count) begin
					$error("match_count: expected %0d, got %0d",
						oldest.match_count, res_if.data.match_count);
					errors++;
				end
				if (res_if.data.unique_res !== oldest.unique_res) begin
					$error("unique_res: expected %0d, got %0d",
						oldest.unique_res, res_if.data.unique_res);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles with no handshake", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		tdc_item_t   rq;
		int unsigned x, y, i, ph, tc, tr, sc, sr, pick;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole store with one random tile repeated
		for (i = 0; i < TILE_PIX; i++)
			base_tile[i] = PIX_W'($urandom);
		for (y = 0; y < STORE_H; y++)
			for (x = 0; x < STORE_W; x++)
				offer(load_req(x, y, base_tile[(y % TILE) * TILE + x % TILE]));

		// directed table
		foreach (DIRECTED[k]) begin
			if (DIRECTED[k].new_cfg)
				set_tiles(DIRECTED[k].across, DIRECTED[k].down);
			rq = '{DIRECTED[k].operation, DIRECTED[k].x, DIRECTED[k].y,
				DIRECTED[k].value, DIRECTED[k].tc, DIRECTED[k].tr};
			offer(rq, DIRECTED[k].src, DIRECTED[k].want);
		end

		// random rounds: mostly edit a tile of the image and query it; some rounds load a stray pixel and query any tile
		for (ph = 0; ph < 4; ph++) begin
			set_tiles(CFG_W'(PHASE_ACROSS[ph]), CFG_W'(PHASE_DOWN[ph]));
			send_idle_pct = SEND_IDLE[ph];
			stall_pct     = STALL[ph];
			repeat (ROUNDS) begin
				tc   = $urandom_range(PHASE_ACROSS[ph] - 1);
				tr   = $urandom_range(PHASE_DOWN[ph] - 1);
				pick = $urandom_range(9);
				if (pick < 2) begin
					// rewrite with the base tile, a likely duplicate
					for (i = 0; i < TILE_PIX; i++)
						offer(load_req(tc * TILE + i % TILE, tr * TILE + i / TILE,
							base_tile[i]));
				end else if (pick < 4) begin
					// copy another tile of the image over this one
					sc = $urandom_range(PHASE_ACROSS[ph] - 1);
					sr = $urandom_range(PHASE_DOWN[ph] - 1);
					for (i = 0; i < TILE_PIX; i++)
						offer(load_req(tc * TILE + i % TILE, tr * TILE + i / TILE,
							pix_at(sc * TILE + i % TILE, sr * TILE + i / TILE)));
				end else if (pick < 8) begin
					// touch a few pixels, sometimes back to the base tile
					repeat ($urandom_range(1, 3)) begin
						i = $urandom_range(TILE_PIX - 1);
						offer(load_req(tc * TILE + i % TILE, tr * TILE + i / TILE,
							$urandom_range(1) ? base_tile[i] : PIX_W'($urandom)));
					end
				end else if (pick == 8) begin
					// stray pixel anywhere, query that may fall outside the image
					offer(load_req($urandom_range(STORE_W - 1), $urandom_range(STORE_H - 1),
						PIX_W'($urandom)));
					tc = $urandom_range(MAX_ACROSS - 1);
					tr = $urandom_range(MAX_DOWN - 1);
				end
				offer(query_req(tc, tr));
			end
		end

		// receiver holds off while queries and loads keep coming
		send_idle_pct = 0;
		stall_pct     = 0;
		set_tiles(1, 1);
		-> hold_off;
		for (i = 0; i < 6; i++) begin
			if (i == 1 || i == 3)
				offer(load_req($urandom_range(TILE - 1), $urandom_range(TILE - 1),
					PIX_W'($urandom)));
			else
				offer(query_req(0, 0));
		end

		wait_quiet();
		$display("covered %0d requests (%0d tile queries), %0d counts checked,",
			n_requests, n_queries, n_results);
		$display("%0d tile count writes, four idle mixes and a %0d cycle receiver hold-off",
			n_cfg_writes, HOLD_CYCLES);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
